FILE: sv/coseas_pkg.sv
// shared types, constants and the 1 - cos table for the cosine ease-in-out stepper
// no dependencies; imported by every module of the block
package coseas_pkg;

  localparam int COORD_W     = 24;   // signed q16.8 coordinate
  localparam int ANGLE_STEPS = 90;   // table steps over a quarter turn
  localparam int FRAC_W      = 15;   // q1.15 cosine
  localparam int ONEMC_W     = 16;   // 1 - cos, up to 1.0 = 32768
  localparam int IDX_W       = $clog2(ANGLE_STEPS + 1);
  localparam int ANG_W       = $clog2(ANGLE_STEPS + 2);
  localparam int PROD_W      = COORD_W + ONEMC_W + 1;
  localparam int SCL_W       = PROD_W - FRAC_W;
  localparam int SUM_W       = SCL_W + 1;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam int S_TDATA_W   = ((1 + 4 * COORD_W) + 7) / 8 * 8;
  localparam int M_TDATA_W   = ((2 * COORD_W + 1) + 7) / 8 * 8;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    KIND_EASE_IN  = 3'b001,
    KIND_EASE_OUT = 3'b010,
    KIND_HOLD     = 3'b100
  } kind_e;

  // one tick as the back end needs it
  typedef struct packed {
    kind_e                      kind;
    logic [IDX_W-1:0]           idx;
    logic signed [COORD_W-1:0]  base_x;
    logic signed [COORD_W-1:0]  base_y;
    logic signed [COORD_W-1:0]  half_x;
    logic signed [COORD_W-1:0]  half_y;
  } tick_t;

  typedef logic [ONEMC_W-1:0] onemc_table_t [ANGLE_STEPS+1];

  // 1 - cos per step, built with integer taylor series at elaboration
  function automatic onemc_table_t gen_onemc_table();
    onemc_table_t       tbl;
    longint unsigned    x;
    longint unsigned    x2;
    longint unsigned    term;
    longint             sum;
    longint unsigned    rom;
    for (int a = 0; a <= ANGLE_STEPS; a++) begin
      x    = (longint'(a) * PI_HALF_Q30) / ANGLE_STEPS;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      // leading one plus twelve series terms, alternating in sign, divisors (2k-1)*2k
      term = ((term * x2) >> 30) / 64'd2;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd12;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd30;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd56;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd90;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd132;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd182;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd240;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd306;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd380;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd462;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd552;
      sum  = sum + longint'(term);
      if (sum < 0) sum = 0;
      rom = ((longint'(sum) << 15) + (64'd1 << 29)) >> 30;
      tbl[a] = ONEMC_W'(64'd32768 - rom);
    end
    return tbl;
  endfunction

  localparam onemc_table_t ONEMC_TABLE = gen_onemc_table();

endpackage

FILE: sv/coseas_front.sv
// front end: takes items, keeps move state, turns ticks into queue entries
// depends on coseas_pkg
module coseas_front
  import coseas_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       mode_i,
  input  logic                       one_axis_i,
  input  logic signed [COORD_W-1:0]  start_x_i,
  input  logic signed [COORD_W-1:0]  start_y_i,
  input  logic signed [COORD_W-1:0]  target_x_i,
  input  logic signed [COORD_W-1:0]  target_y_i,
  output logic                       push_o,
  output tick_t                      tick_o
);

  typedef enum logic [2:0] {
    PH_EASE_IN  = 3'b001,
    PH_EASE_OUT = 3'b010,
    PH_DONE     = 3'b100
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [ANG_W-1:0]          angle_q, angle_d;
  logic signed [COORD_W-1:0] origin_x_q, origin_x_d, origin_y_q, origin_y_d;
  logic signed [COORD_W-1:0] target_x_q, target_x_d, target_y_q, target_y_d;
  logic signed [COORD_W-1:0] half_x_q, half_x_d, half_y_q, half_y_d;
  logic signed [COORD_W:0]   full_x, full_y;

  assign full_x = {target_x_i[COORD_W-1], target_x_i} - {start_x_i[COORD_W-1], start_x_i};
  assign full_y = {target_y_i[COORD_W-1], target_y_i} - {start_y_i[COORD_W-1], start_y_i};

  always_comb begin
    phase_d    = phase_q;
    angle_d    = angle_q;
    origin_x_d = origin_x_q;
    origin_y_d = origin_y_q;
    target_x_d = target_x_q;
    target_y_d = target_y_q;
    half_x_d   = half_x_q;
    half_y_d   = half_y_q;
    push_o     = 1'b0;
    tick_o.kind   = KIND_HOLD;
    tick_o.idx    = angle_q[IDX_W-1:0];
    tick_o.base_x = origin_x_q;
    tick_o.base_y = origin_y_q;
    tick_o.half_x = half_x_q;
    tick_o.half_y = half_y_q;
    if (accept_i) begin
      if (mode_i == MODE_START) begin
        phase_d    = PH_EASE_IN;
        angle_d    = '0;
        origin_x_d = start_x_i;
        target_x_d = target_x_i;
        half_x_d   = full_x[COORD_W:1];   // floor of half
        if (one_axis_i) begin
          origin_y_d = '0;
          target_y_d = '0;
          half_y_d   = '0;
        end else begin
          origin_y_d = start_y_i;
          target_y_d = target_y_i;
          half_y_d   = full_y[COORD_W:1];
        end
      end else begin
        push_o = 1'b1;
        unique case (phase_q)
          PH_EASE_IN: begin
            tick_o.kind = KIND_EASE_IN;
            angle_d     = angle_q + ANG_W'(1);
            if (angle_q == ANG_W'(ANGLE_STEPS)) phase_d = PH_EASE_OUT;
          end
          PH_EASE_OUT: begin
            tick_o.kind   = KIND_EASE_OUT;
            tick_o.base_x = target_x_q;
            tick_o.base_y = target_y_q;
            angle_d       = angle_q - ANG_W'(1);
            // stepping below zero reads the table at one step
            if (angle_q == '0) begin
              tick_o.idx = IDX_W'(1);
              phase_d    = PH_DONE;
            end else begin
              tick_o.idx = IDX_W'(angle_q - ANG_W'(1));
            end
          end
          default: begin
            tick_o.kind = KIND_HOLD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
      angle_q <= '0;
    end else begin
      phase_q <= phase_d;
      angle_q <= angle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    origin_x_q <= origin_x_d;
    origin_y_q <= origin_y_d;
    target_x_q <= target_x_d;
    target_y_q <= target_y_d;
    half_x_q   <= half_x_d;
    half_y_q   <= half_y_d;
  end

endmodule

FILE: sv/coseas_queue.sv
// short fifo of tick entries between front and back end
// depends on coseas_pkg
module coseas_queue
  import coseas_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  tick_t push_data_i,
  output logic  full_o,
  output logic  valid_o,
  output tick_t data_o,
  input  logic  pop_i
);

  tick_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (do_push && !do_pop)      count_q <= count_q + QCNT_W'(1);
      else if (do_pop && !do_push) count_q <= count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

FILE: sv/coseas_back.sv
// back end: table lookup and multiply, then offset, saturate and output register
// depends on coseas_pkg
module coseas_back
  import coseas_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  tick_t                      tick_i,
  output logic                       pop_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic signed [COORD_W-1:0]  eased_x_o,
  output logic signed [COORD_W-1:0]  eased_y_o,
  output logic                       done_o
);

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0]  SAT_HI = SUM_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0]  SAT_LO = -SAT_HI - SUM_W'(1);

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_HI)      r = SAT_HI[COORD_W-1:0];
    else if (v < SAT_LO) r = SAT_LO[COORD_W-1:0];
    else                 r = v[COORD_W-1:0];
    return r;
  endfunction

  logic                      s1_valid_q;
  kind_e                     s1_kind_q;
  logic signed [COORD_W-1:0] s1_base_x_q, s1_base_y_q;
  logic signed [PROD_W-1:0]  s1_prod_x_q, s1_prod_y_q;
  logic                      s2_valid_q;
  logic signed [COORD_W-1:0] s2_x_q, s2_y_q;
  logic                      s2_done_q;

  logic                      s1_ready, s2_ready;
  logic [ONEMC_W-1:0]        onemc;
  logic signed [PROD_W-1:0]  prod_x, prod_y;
  logic signed [SUM_W-1:0]   base_x, base_y, scl_x, scl_y, sum_x, sum_y;

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign pop_o    = valid_i && s1_ready;

  // stage one: 1 - cos lookup and rounded product per axis
  assign onemc  = ONEMC_TABLE[tick_i.idx];
  assign prod_x = tick_i.half_x * $signed({1'b0, onemc}) + ROUND_BIAS;
  assign prod_y = tick_i.half_y * $signed({1'b0, onemc}) + ROUND_BIAS;

  // stage two: floor shift, offset from origin or target, saturate
  assign scl_x  = SUM_W'($signed(s1_prod_x_q[PROD_W-1:FRAC_W]));
  assign scl_y  = SUM_W'($signed(s1_prod_y_q[PROD_W-1:FRAC_W]));
  assign base_x = SUM_W'(s1_base_x_q);
  assign base_y = SUM_W'(s1_base_y_q);
  assign sum_x  = (s1_kind_q == KIND_EASE_OUT) ? base_x - scl_x : base_x + scl_x;
  assign sum_y  = (s1_kind_q == KIND_EASE_OUT) ? base_y - scl_y : base_y + scl_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_x_q     <= '0;
      s2_y_q     <= '0;
      s2_done_q  <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s2_ready && s1_valid_q) begin
        // a hold tick leaves the last point in place
        if (s1_kind_q == KIND_HOLD) begin
          s2_done_q <= 1'b1;
        end else begin
          s2_x_q    <= sat(sum_x);
          s2_y_q    <= sat(sum_y);
          s2_done_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_kind_q   <= tick_i.kind;
      s1_base_x_q <= tick_i.base_x;
      s1_base_y_q <= tick_i.base_y;
      s1_prod_x_q <= prod_x;
      s1_prod_y_q <= prod_y;
    end
  end

  assign valid_o   = s2_valid_q;
  assign eased_x_o = s2_x_q;
  assign eased_y_o = s2_y_q;
  assign done_o    = s2_done_q;

endmodule

FILE: sv/cosine_ease_in_out_stepper_unit.sv
// top level of the cosine ease-in-out stepper: front end, tick queue, back end
// depends on coseas_pkg, coseas_front, coseas_queue, coseas_back
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tuser: mode; tdata: one_axis, start/target x/y
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: eased_x, eased_y, done_res
//
// one word a cycle while the tick queue has room; a tick word's result passes the queue write,
// lookup and multiply, and offset and saturate registers, a start word gives none
// input ready follows the four-entry tick queue only, so starts and ticks flow
// while a result waits at the output register
// reset puts the stepper in its finished state with the held point at zero
module cosine_ease_in_out_stepper_unit
  import coseas_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // one_axis, start_x, start_y, target_x, target_y
  input  logic                  s_axis_tuser,   // mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata    // eased_x, eased_y, done_res
);

  logic                      accept;
  logic                      push, q_full, q_valid, q_pop;
  tick_t                     push_tick, q_tick;
  logic signed [COORD_W-1:0] eased_x, eased_y;
  logic                      done_res;

  // a start never enters the queue but is held back with ticks for simplicity
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  coseas_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .mode_i     (s_axis_tuser),
    .one_axis_i (s_axis_tdata[0]),
    .start_x_i  ($signed(s_axis_tdata[COORD_W:1])),
    .start_y_i  ($signed(s_axis_tdata[2*COORD_W:COORD_W+1])),
    .target_x_i ($signed(s_axis_tdata[3*COORD_W:2*COORD_W+1])),
    .target_y_i ($signed(s_axis_tdata[4*COORD_W:3*COORD_W+1])),
    .push_o     (push),
    .tick_o     (push_tick)
  );

  coseas_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_tick),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_tick),
    .pop_i       (q_pop)
  );

  coseas_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .tick_i    (q_tick),
    .pop_o     (q_pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .eased_x_o (eased_x),
    .eased_y_o (eased_y),
    .done_o    (done_res)
  );

  // pack result word, zero fill to whole bytes
  assign m_axis_tdata = M_TDATA_W'({done_res, eased_y, eased_x});

endmodule
